@@ sv/indoor_bike_data_field_parser_macros.svh @@
// Shared assertion macros for the indoor bike data parser.
`ifndef INDOOR_BIKE_DATA_FIELD_PARSER_MACROS_SVH
`define INDOOR_BIKE_DATA_FIELD_PARSER_MACROS_SVH

// Check that a condition holds on every clock edge outside reset.
`define IBD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define IBD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define IBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/ibd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ibd_pkg;

	localparam logic [3:0] FIELD_COUNT   = 4'd13;
	localparam logic [3:0] FID_RESISTANCE = 4'd5;
	localparam logic [3:0] FID_POWER      = 4'd6;
	localparam logic [3:0] FID_AVG_POWER  = 4'd7;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_SHORT = 2'd1,
		ST_TRUNCATED = 2'd2
	} status_t;

	typedef enum logic {
		KIND_FIELD  = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  field_id;
		logic [40:0] field_value;
		logic [15:0] packet_flags;
		status_t     status;
		logic [3:0]  truncated_field;
		logic [4:0]  bytes_consumed;
		logic [7:0]  bytes_trailing;
		logic        last_of_run;
	} result_t;

	// byte length of each field
	function automatic logic [2:0] field_len(logic [3:0] fid);
		logic [2:0] len;
		unique case (fid)
			4'd4:          len = 3'd3;
			4'd8:          len = 3'd5;
			4'd9, 4'd10:   len = 3'd1;
			default:       len = 3'd2;
		endcase
		return len;
	endfunction

	// one bit per field; speed is present when flag bit 0 is clear
	function automatic logic [12:0] present_mask(logic [15:0] flags);
		return {flags[12:1], ~flags[0]};
	endfunction

	// first present field at or after from; FIELD_COUNT when none
	function automatic logic [3:0] next_field(logic [12:0] mask, logic [3:0] from);
		logic [3:0] r;
		r = FIELD_COUNT;
		for (int i = 12; i >= 0; i--) begin
			if (mask[i] && (4'(i) >= from)) begin
				r = 4'(i);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ sv/ibd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "indoor_bike_data_field_parser_macros.svh"
module ibd_front
	import ibd_pkg::*;
#(
	parameter int unsigned TRAILING_MAX = 255
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_eop,
	output result_t         res0,
	output result_t         res1,
	output logic [1:0]      res_n
);

	localparam logic [7:0] TRAIL_CAP = (TRAILING_MAX > 255) ? 8'd255 : 8'(TRAILING_MAX);

	logic [4:0]  off_q, off_d;
	logic [15:0] flags_q, flags_d;
	logic [3:0]  cur_q, cur_d;
	logic [2:0]  idx_q, idx_d;
	logic [4:0]  start_q, start_d;
	logic [39:0] acc_q, acc_d;
	logic [7:0]  trail_q, trail_d;
	logic        done_q, done_d;
	logic [1:0]  n;

	always_comb begin
		logic [39:0] acc_new;
		logic [2:0]  idx_new;
		logic [3:0]  nf;
		logic        begin_fld;
		result_t     fld;
		result_t     stat;
		off_d     = off_q;
		flags_d   = flags_q;
		cur_d     = cur_q;
		idx_d     = idx_q;
		start_d   = start_q;
		acc_d     = acc_q;
		trail_d   = trail_q;
		done_d    = done_q;
		acc_new   = '0;
		idx_new   = '0;
		nf        = '0;
		begin_fld = 1'b0;
		fld       = '0;
		stat      = '0;
		n         = 2'd0;
		res0      = '0;
		res1      = '0;

		if (off_q == 5'd0) begin
			flags_d = {8'h00, in_byte};
			off_d   = 5'd1;
		end else if (off_q == 5'd1) begin
			flags_d   = {in_byte, flags_q[7:0]};
			off_d     = 5'd2;
			nf        = next_field(present_mask(flags_d), 4'd0);
			begin_fld = 1'b1;
		end else if (!done_q) begin
			acc_new = acc_q | ({32'h0, in_byte} << {idx_q, 3'b000});
			idx_new = idx_q + 3'd1;
			off_d   = off_q + 5'd1;
			acc_d   = acc_new;
			idx_d   = idx_new;
			if (idx_new >= field_len(cur_q)) begin
				fld.kind     = KIND_FIELD;
				fld.field_id = cur_q;
				if (cur_q == FID_RESISTANCE || cur_q == FID_POWER ||
						cur_q == FID_AVG_POWER) begin
					fld.field_value = {{25{acc_new[15]}}, acc_new[15:0]};
				end else begin
					fld.field_value = {1'b0, acc_new};
				end
				fld.last_of_run = !in_eop;
				n         = 2'd1;
				nf        = next_field(present_mask(flags_q), cur_q + 4'd1);
				begin_fld = 1'b1;
			end
		end else if (trail_q < TRAIL_CAP) begin
			trail_d = trail_q + 8'd1;
		end

		// open the next present field, or mark the field list finished
		if (begin_fld) begin
			if (nf >= FIELD_COUNT) begin
				done_d = 1'b1;
				cur_d  = 4'd0;
			end else begin
				cur_d = nf;
			end
			idx_d   = 3'd0;
			start_d = off_d;
			acc_d   = '0;
		end

		if (in_eop) begin
			stat.kind        = KIND_STATUS;
			stat.last_of_run = 1'b1;
			if (off_q == 5'd0) begin
				stat.status = ST_TOO_SHORT;
			end else begin
				stat.packet_flags = flags_d;
				if (done_d) begin
					stat.status         = ST_OK;
					stat.bytes_consumed = off_d;
					stat.bytes_trailing = trail_d;
				end else begin
					stat.status          = ST_TRUNCATED;
					stat.truncated_field = cur_d;
					stat.bytes_consumed  = start_d;
				end
			end
			// return to the reset state for the next packet
			off_d   = '0;
			flags_d = '0;
			cur_d   = '0;
			idx_d   = '0;
			start_d = '0;
			acc_d   = '0;
			trail_d = '0;
			done_d  = 1'b0;
		end

		if (n == 2'd1) begin
			res0 = fld;
			if (in_eop) begin
				res1 = stat;
				n    = 2'd2;
			end
		end else if (in_eop) begin
			res0 = stat;
			n    = 2'd1;
		end
	end

	assign res_n = accept ? n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			flags_q <= '0;
			cur_q   <= '0;
			idx_q   <= '0;
			start_q <= '0;
			acc_q   <= '0;
			trail_q <= '0;
			done_q  <= 1'b0;
		end else if (accept) begin
			off_q   <= off_d;
			flags_q <= flags_d;
			cur_q   <= cur_d;
			idx_q   <= idx_d;
			start_q <= start_d;
			acc_q   <= acc_d;
			trail_q <= trail_d;
			done_q  <= done_d;
		end
	end

	`IBD_ASSERT_IMPL(a_eop_gives_status, accept && in_eop, res_n != 2'd0, "eop without status")
	`IBD_ASSERT_IMPL(a_pair_order, res_n == 2'd2,
		res0.kind == KIND_FIELD && res1.kind == KIND_STATUS, "bad result pair order")
	`IBD_ASSERT_ALWAYS(a_done_clears_field, !done_q || cur_q == 4'd0, "field id kept after done")

endmodule
`default_nettype wire

@@ sv/ibd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "indoor_bike_data_field_parser_macros.svh"
module ibd_queue
	import ibd_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire result_t    push0,
	input  wire result_t    push1,
	input  wire logic [1:0] push_n,
	output logic            room,
	output result_t         head,
	output logic            head_valid,
	input  wire logic       pop_ready
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	result_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q, wr_next;
	logic [CW-1:0]   cnt_q;
	logic            pop;

	function automatic logic [PW-1:0] wrap_inc(logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_next    = wrap_inc(wr_ptr_q);
	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (cnt_q != '0);
	assign pop        = head_valid && pop_ready;
	// two free entries so that a field result and a status can land together
	assign room       = (cnt_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_next] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_n == 2'd1) begin
				wr_ptr_q <= wr_next;
			end else if (push_n == 2'd2) begin
				wr_ptr_q <= wrap_inc(wr_next);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

	`IBD_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(DEPTH), "queue count past depth")
	`IBD_ASSERT_IMPL(a_push_room, push_n != 2'd0, room, "push without room")
	`IBD_ASSERT_NEXT(a_pair_count, push_n == 2'd2 && !pop,
		cnt_q == $past(cnt_q) + CW'(2), "pair push miscounted")

endmodule
`default_nettype wire

@@ sv/indoor_bike_data_field_parser.sv @@
// Indoor bike data parser: one packet byte per item in, field and status items out.
// Order: when the queue is empty, the first result of a byte is offered on m_axis in the
// cycle after the byte is taken, and the second of a pair once the first has been taken.
// Throughput: one byte per cycle; a byte is taken whenever the result queue has two
// free entries, and the queue drains one result per cycle while m_axis_tready is high.
// Reset: arst_n clears the parser state and the queue pointers asynchronously.
`timescale 1ns / 1ps
`default_nettype none
module indoor_bike_data_field_parser
	import ibd_pkg::*;
#(
	parameter int unsigned TRAILING_MAX = 255,
	parameter int unsigned QUEUE_DEPTH  = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // packet_byte[7:0]
	input  wire logic        s_axis_tlast,  // end_of_packet
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// field_id[3:0], field_value[44:4], packet_flags[60:45], status[62:61],
	// truncated_field[66:63], bytes_consumed[71:67], bytes_trailing[79:72]
	output logic [79:0]      m_axis_tdata,
	output logic             m_axis_tuser,  // kind
	output logic             m_axis_tlast   // last_of_run
);

	result_t    res0, res1, head;
	logic [1:0] res_n;
	logic       room;
	logic       accept;

	// take a byte only when both results it may cause fit into the queue
	assign s_axis_tready = room;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// front: run the flag word and field walk, classify each byte into results
	ibd_front #(
		.TRAILING_MAX (TRAILING_MAX)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (s_axis_tdata),
		.in_eop  (s_axis_tlast),
		.res0    (res0),
		.res1    (res1),
		.res_n   (res_n)
	);

	// back: hold results until the downstream side takes them
	ibd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push0      (res0),
		.push1      (res1),
		.push_n     (res_n),
		.room       (room),
		.head       (head),
		.head_valid (m_axis_tvalid),
		.pop_ready  (m_axis_tready)
	);

	// pack the head result, first field in the lowest bits
	assign m_axis_tdata = {head.bytes_trailing, head.bytes_consumed, head.truncated_field,
		head.status, head.packet_flags, head.field_value, head.field_id};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last_of_run;

endmodule
`default_nettype wire

@@ tb/tb_indoor_bike_data_field_parser.sv @@
`timescale 1ns / 1ps
module tb_indoor_bike_data_field_parser
	import ibd_pkg::*;
();

	// Clock period and the pause allowed at the end once nothing is pending.
	localparam int CLK_PERIOD   = 8;
	localparam int DRAIN_CYCLES = 20;
	// Trailing bytes saturate at the smaller of the block's limit and 255.
	localparam int TRAIL_CAP    = 255;

	// Field ids whose length is not the usual two bytes.
	localparam logic [3:0] FID_DISTANCE   = 4'd4;
	localparam logic [3:0] FID_ENERGY     = 4'd8;
	localparam logic [3:0] FID_HEART_RATE = 4'd9;
	localparam logic [3:0] FID_MET        = 4'd10;

	// Flag words used by the directed tests.
	localparam logic [15:0] FLAGS_NONE       = 16'h0001;  // speed absent, nothing else
	localparam logic [15:0] FLAGS_SPEED_ONLY = 16'h0000;
	localparam logic [15:0] FLAGS_HIGH_ONLY  = 16'hE001;  // bits 13..15 add no field
	localparam logic [15:0] FLAGS_ALL        = 16'h1FFE;  // all thirteen fields
	localparam logic [15:0] FLAGS_ALL_HIGH   = 16'hFFFE;
	localparam logic [15:0] FLAGS_ENERGY     = 16'h0101;  // energy alone

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	// Idle percentages for the byte sender and the result receiver.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int errors = 0;

	// Results still owed by the block, oldest first.
	result_t pending_results[$];

	// Parser state as the block should hold it.
	logic [4:0]  offset_q;
	logic [15:0] flags_q;
	logic [3:0]  field_q;
	logic [2:0]  fbyte_q;
	logic [4:0]  fstart_q;
	logic [39:0] accum_q;
	logic [7:0]  trail_q;
	logic        done_q;

	indoor_bike_data_field_parser DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int field_bytes(int fid);
		case (fid)
			FID_DISTANCE:            return 3;
			FID_ENERGY:              return 5;
			FID_HEART_RATE, FID_MET: return 1;
			default:                 return 2;
		endcase
	endfunction

	// Speed is flagged by a clear bit 0; every other field by its own bit.
	function automatic bit field_flagged(logic [15:0] flags, int fid);
		return (fid == 0) ? !flags[0] : flags[fid];
	endfunction

	function automatic int first_flagged(logic [15:0] flags, int from);
		int fid;
		fid = from;
		while (fid < FIELD_COUNT && !field_flagged(flags, fid))
			fid++;
		return fid;
	endfunction

	// Total packet length that carries every flagged field and no trailer.
	function automatic int packet_bytes(logic [15:0] flags);
		int len;
		len = 2;
		for (int fid = 0; fid < FIELD_COUNT; fid++)
			if (field_flagged(flags, fid))
				len += field_bytes(fid);
		return len;
	endfunction

	task automatic clear_parser();
		offset_q = '0;
		flags_q  = '0;
		field_q  = '0;
		fbyte_q  = '0;
		fstart_q = '0;
		accum_q  = '0;
		trail_q  = '0;
		done_q   = 1'b0;
	endtask

	// Move on to the given field, or mark the field list done past the last one.
	task automatic open_field(int fid);
		if (fid >= FIELD_COUNT) begin
			done_q  = 1'b1;
			field_q = '0;
		end else begin
			field_q = 4'(fid);
		end
		fbyte_q  = '0;
		fstart_q = offset_q;
		accum_q  = '0;
	endtask

	// Work out the results that one accepted packet byte causes and queue them.
	task automatic predict_byte(input logic [7:0] b, input logic eop);
		result_t r;
		result_t made[$];
		logic [40:0] val;
		begin
			if (offset_q == 5'd0) begin
				// A lone first byte can only end in a too-short status.
				flags_q  = {8'h00, b};
				offset_q = 5'd1;
				if (eop) begin
					r = '0;
					r.kind = KIND_STATUS;
					r.status = ST_TOO_SHORT;
					r.last_of_run = 1'b1;
					pending_results.push_back(r);
					clear_parser();
				end
				return;
			end
			if (offset_q == 5'd1) begin
				flags_q[15:8] = b;
				offset_q = 5'd2;
				open_field(first_flagged(flags_q, 0));
			end else if (!done_q) begin
				accum_q = accum_q | (40'(b) << (8 * fbyte_q));
				fbyte_q = fbyte_q + 3'd1;
				offset_q = offset_q + 5'd1;
				if (fbyte_q >= field_bytes(field_q)) begin
					// Resistance and both power fields are signed 16-bit values.
					if (field_q == FID_RESISTANCE || field_q == FID_POWER ||
							field_q == FID_AVG_POWER)
						val = {{25{accum_q[15]}}, accum_q[15:0]};
					else
						val = {1'b0, accum_q};
					r = '0;
					r.kind = KIND_FIELD;
					r.field_id = field_q;
					r.field_value = val;
					made.push_back(r);
					open_field(first_flagged(flags_q, field_q + 1));
				end
			end else if (trail_q < TRAIL_CAP) begin
				trail_q = trail_q + 8'd1;
			end

			if (eop) begin
				r = '0;
				r.kind = KIND_STATUS;
				r.packet_flags = flags_q;
				if (done_q) begin
					r.status = ST_OK;
					r.bytes_consumed = offset_q;
					r.bytes_trailing = trail_q;
				end else begin
					r.status = ST_TRUNCATED;
					r.truncated_field = field_q;
					r.bytes_consumed = fstart_q;
				end
				made.push_back(r);
				clear_parser();
			end

			if (made.size() > 0)
				made[made.size() - 1].last_of_run = 1'b1;
			foreach (made[i])
				pending_results.push_back(made[i]);
		end
	endtask

	// ---------------------------------------------------------------- checker

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	task automatic check_result();
		result_t want;
		if (pending_results.size() == 0) begin
			$error("result item with nothing pending: tuser %0b tdata %h",
				m_axis_tuser, m_axis_tdata);
			errors++;
		end else begin
			want = pending_results.pop_front();
			check_field("kind",            want.kind,            m_axis_tuser);
			check_field("field_id",        want.field_id,        m_axis_tdata[3:0]);
			check_field("field_value",     want.field_value,     m_axis_tdata[44:4]);
			check_field("packet_flags",    want.packet_flags,    m_axis_tdata[60:45]);
			check_field("status",          want.status,          m_axis_tdata[62:61]);
			check_field("truncated_field", want.truncated_field, m_axis_tdata[66:63]);
			check_field("bytes_consumed",  want.bytes_consumed,  m_axis_tdata[71:67]);
			check_field("bytes_trailing",  want.bytes_trailing,  m_axis_tdata[79:72]);
			check_field("last_of_run",     want.last_of_run,     m_axis_tlast);
		end
	endtask

	// Sample both handshakes on the edge that completes them; a byte's results
	// appear in the following cycle at the earliest, so the order here is free.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				check_result();
		end
	end

	// Receiver stalls at random.
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	// ---------------------------------------------------------------- stimulus

	// Offer one byte after a random idle gap and hold it until it is taken.
	task automatic send_item(input logic [7:0] b, input logic eop);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eop;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h80;
			3:       return 8'h7F;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Send a packet of len bytes: flag word first, then either random bytes or
	// an alternating even/odd pattern; the final byte carries the end mark.
	task automatic send_packet(input logic [15:0] flags, input int len,
			input logic [7:0] even_byte, input logic [7:0] odd_byte, input bit random_body);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			if (i == 0)
				b = flags[7:0];
			else if (i == 1)
				b = flags[15:8];
			else if (random_body)
				b = rand_byte();
			else
				b = i[0] ? odd_byte : even_byte;
			send_item(b, i == len - 1);
		end
	endtask

	// Hold the sender until every owed result has been taken.
	task automatic wait_for_drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// One-byte packets and packets that end inside the flag word.
	task automatic test_short_packets();
		send_packet(16'h0000, 1, 8'h00, 8'h00, 1'b0);
		send_packet(16'h00FF, 1, 8'h00, 8'h00, 1'b0);
		send_packet(FLAGS_NONE, 2, 8'h00, 8'h00, 1'b0);
		send_packet(FLAGS_SPEED_ONLY, 2, 8'h00, 8'h00, 1'b0);
		send_packet(FLAGS_HIGH_ONLY, 2, 8'h00, 8'h00, 1'b0);
	endtask

	// Every field present, at the extremes of the signed and unsigned ranges.
	task automatic test_all_fields();
		send_packet(FLAGS_ALL, packet_bytes(FLAGS_ALL), 8'hFF, 8'hFF, 1'b0);
		send_packet(FLAGS_ALL_HIGH, packet_bytes(FLAGS_ALL_HIGH), 8'h00, 8'h80, 1'b0);
		send_packet(FLAGS_ALL, packet_bytes(FLAGS_ALL), 8'hFF, 8'h7F, 1'b0);
		// Energy cut off after three of its five bytes.
		send_packet(FLAGS_ENERGY, 5, 8'h5A, 8'hA5, 1'b0);
	endtask

	// Trailing bytes after the last field: a few, then enough to saturate.
	task automatic test_trailing_bytes();
		send_packet(FLAGS_NONE, 5, 8'h12, 8'h34, 1'b0);
		send_packet(FLAGS_SPEED_ONLY, 4 + 260, 8'hC3, 8'h3C, 1'b0);
	endtask

	// Mostly complete packets with random content, plus truncated packets,
	// lone bytes and packets of random length.
	task automatic test_random_packets(input int n_items);
		int sent;
		int pick;
		int need;
		int len;
		logic [15:0] flags;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(3))
				0:       flags = 16'($urandom) & 16'($urandom);
				1:       flags = 16'($urandom) | FLAGS_ALL;
				default: flags = 16'($urandom);
			endcase
			need = packet_bytes(flags);
			pick = $urandom_range(99);
			if (pick < 70)
				len = need + (($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
			else if (pick < 85)
				len = (need > 2) ? $urandom_range(2, need - 1) : 2;
			else if (pick < 92)
				len = 1;
			else
				len = $urandom_range(1, 40);
			send_packet(flags, len, 8'h00, 8'h00, 1'b1);
			sent += len;
		end
	endtask

	initial begin
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 8'h00;
		s_axis_tlast  <= 1'b0;
		clear_parser();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender mostly busy, receiver mostly stalled.
		send_idle_pct = 11;
		recv_idle_pct = 70;
		test_short_packets();
		test_all_fields();
		test_random_packets(25);
		wait_for_drain();

		// Sender mostly idle, receiver mostly ready.
		send_idle_pct = 70;
		recv_idle_pct = 11;
		test_trailing_bytes();
		test_random_packets(25);
		wait_for_drain();

		// Full rate on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_packets(25);

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
